@@ src/ddo_pkg.sv @@
// package: shared constants, command types and arctangent table for the odometry block
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CNT_W = 5;
  localparam logic [32:0] RAD_TO_BAM = 33'd683565276;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;

  localparam logic REG_MPT = 1'b0;
  localparam logic REG_ITRACK = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD,
    OP_MUL_SUM, OP_MUL_DIFF, OP_TAKE_DF, OP_MUL_TURN, OP_TAKE_R40,
    OP_MUL_RLO, OP_MUL_RHI, OP_ACC_RHI, OP_CORDIC_START, OP_CORDIC_STEP,
    OP_MUL_DCOS, OP_MUL_DSIN, OP_TAKE_LY, OP_MUL_CLX, OP_MUL_SLY,
    OP_MUL_SLX, OP_MUL_CLY, OP_SUM_DY, OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ src/ddo_cordic.sv @@
// module: iterative rotation-mode cordic giving cos and sin of a binary angle
`timescale 1ns / 1ps
module ddo_cordic (
  input  logic                clk,
  input  logic                start,
  input  logic                step,
  input  logic [4:0]          iter,
  input  logic [31:0]         angle,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o
);
  import ddo_pkg::*;

  logic signed [32:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic signed [32:0] xs, ys, xo, yo;
  logic [31:0]        a2, at;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    xs = x_r >>> iter;
    ys = y_r >>> iter;
    at = atan_bam(iter);
    a2 = angle;
    if (start) begin
      // second and third quadrant: turn by half a turn, negate at the end
      flip_nxt = angle[31] ^ angle[30];
      a2 = flip_nxt ? angle - 32'h80000000 : angle;
      x_nxt = CORDIC_GAIN;
      y_nxt = '0;
      z_nxt = signed'(a2);
    end else if (step) begin
      if (!z_r[31]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - signed'(at);
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + signed'(at);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign xo = flip_r ? -x_r : x_r;
  assign yo = flip_r ? -y_r : y_r;
  assign cos_o = xo[31:0];
  assign sin_o = yo[31:0];

endmodule

@@ src/ddo_dpath.sv @@
// module: odometry datapath with shared multiplier, accumulator, pose and output register
`timescale 1ns / 1ps
module ddo_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  ddo_pkg::cmd_t cmd,
  output ddo_pkg::stat_t stat,
  input  logic [31:0]   in_tdata,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [95:0]   out_tdata
);
  import ddo_pkg::*;

  logic [31:0] mpt_r, itrack_r;
  logic signed [15:0] lt_r, rt_r;
  logic signed [65:0] p_r, p_nxt;
  logic signed [32:0] ma, mb;
  logic signed [71:0] acc_r, acc_nxt, p_ext;
  logic signed [31:0] d_r, df_r, dx_r;
  logic [63:0] r40_r;
  logic signed [32:0] lx_r, ly_r, df_t;
  logic signed [65:0] p_neg;
  logic [31:0] dh_r, px_r, py_r, hd_r;
  logic out_valid_r;
  logic signed [31:0] cd, sd, ch, sh;
  logic cs_start, cs_step;

  assign cs_start = (cmd.op == OP_CORDIC_START);
  assign cs_step = (cmd.op == OP_CORDIC_STEP);

  ddo_cordic u_cor_dh (
    .clk(clk), .start(cs_start), .step(cs_step), .iter(5'(cmd.iter)),
    .angle(acc_r[71:40]), .cos_o(cd), .sin_o(sd));

  ddo_cordic u_cor_hd (
    .clk(clk), .start(cs_start), .step(cs_step), .iter(5'(cmd.iter)),
    .angle(hd_r), .cos_o(ch), .sin_o(sh));

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_SUM:  begin ma = 33'(lt_r) + 33'(rt_r); mb = {1'b0, mpt_r}; end
      OP_MUL_DIFF: begin ma = 33'(rt_r) - 33'(lt_r); mb = {1'b0, mpt_r}; end
      OP_MUL_TURN: begin ma = 33'(df_r); mb = {1'b0, itrack_r}; end
      OP_MUL_RLO:  begin ma = {1'b0, r40_r[31:0]}; mb = RAD_TO_BAM; end
      OP_MUL_RHI:  begin ma = 33'(signed'(r40_r[63:32])); mb = RAD_TO_BAM; end
      OP_MUL_DCOS: begin ma = 33'(d_r); mb = 33'(cd); end
      OP_MUL_DSIN: begin ma = 33'(d_r); mb = 33'(sd); end
      OP_MUL_CLX:  begin ma = 33'(ch); mb = lx_r; end
      OP_MUL_SLY:  begin ma = 33'(sh); mb = ly_r; end
      OP_MUL_SLX:  begin ma = 33'(sh); mb = lx_r; end
      OP_MUL_CLY:  begin ma = 33'(ch); mb = ly_r; end
      default:     begin ma = '0; mb = '0; end
    endcase
    p_nxt = ma * mb;
  end

  assign p_ext = 72'(p_r);
  assign p_neg = -p_r;
  assign df_t = p_r[48:16];

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.op) inside
      OP_MUL_RHI, OP_MUL_SLY, OP_MUL_CLY: acc_nxt = p_ext;
      OP_ACC_RHI: acc_nxt = acc_r + (p_ext <<< 32);
      OP_MUL_SLX: acc_nxt = acc_r - p_ext;
      OP_SUM_DY:  acc_nxt = acc_r + p_ext;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    acc_r <= acc_nxt;
    case (cmd.op)
      OP_LOAD:     begin lt_r <= signed'(in_tdata[15:0]); rt_r <= signed'(in_tdata[31:16]); end
      OP_MUL_DIFF: d_r <= p_r[48:17];
      OP_TAKE_DF: begin
        if (df_t[32] != df_t[31])
          df_r <= df_t[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
          df_r <= df_t[31:0];
      end
      OP_TAKE_R40:     r40_r <= p_r[63:0];
      OP_CORDIC_START: dh_r <= acc_r[71:40];
      OP_MUL_DSIN:     lx_r <= p_r[62:30];
      OP_TAKE_LY:      ly_r <= p_neg[62:30];
      OP_MUL_CLY:      dx_r <= acc_r[61:30];
      default: ;
    endcase
  end

  // config registers, pose and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= '0;
      itrack_r <= '0;
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MPT:    mpt_r <= cfg_wdata;
          REG_ITRACK: itrack_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == OP_UPDATE) begin
        px_r <= px_r + dx_r;
        py_r <= py_r + acc_r[61:30];
        hd_r <= hd_r + dh_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {hd_r, py_r, px_r};

endmodule

@@ src/ddo_ctrl.sv @@
// module: sequencer that steps the odometry datapath through one update
`timescale 1ns / 1ps
module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ddo_pkg::stat_t stat,
  output ddo_pkg::cmd_t  cmd
);
  import ddo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_PRE = 5'b00010, S_CORD = 5'b00100,
    S_POST = 5'b01000, S_DONE = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(8);
  localparam logic [CNT_W-1:0] POST_LAST = CNT_W'(7);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t pre_op, post_op;

  always_comb begin
    case (cnt_r)
      CNT_W'(0): pre_op = OP_MUL_SUM;
      CNT_W'(1): pre_op = OP_MUL_DIFF;
      CNT_W'(2): pre_op = OP_TAKE_DF;
      CNT_W'(3): pre_op = OP_MUL_TURN;
      CNT_W'(4): pre_op = OP_TAKE_R40;
      CNT_W'(5): pre_op = OP_MUL_RLO;
      CNT_W'(6): pre_op = OP_MUL_RHI;
      CNT_W'(7): pre_op = OP_ACC_RHI;
      default:   pre_op = OP_CORDIC_START;
    endcase
    case (cnt_r)
      CNT_W'(0): post_op = OP_MUL_DCOS;
      CNT_W'(1): post_op = OP_MUL_DSIN;
      CNT_W'(2): post_op = OP_TAKE_LY;
      CNT_W'(3): post_op = OP_MUL_CLX;
      CNT_W'(4): post_op = OP_MUL_SLY;
      CNT_W'(5): post_op = OP_MUL_SLX;
      CNT_W'(6): post_op = OP_MUL_CLY;
      default:   post_op = OP_SUM_DY;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r + CNT_W'(1);
    cmd.iter = cnt_r;
    cmd.op = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.op = pre_op;
        if (cnt_r == PRE_LAST) begin
          cnt_nxt = '0;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op = OP_CORDIC_STEP;
        if (cnt_r == CORD_LAST) begin
          cnt_nxt = '0;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        cmd.op = post_op;
        if (cnt_r == POST_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_UPDATE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_cord_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORD |-> cnt_r <= CORD_LAST) else $error("cordic count overrun");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_PRE && cnt_r == '0)
    else $error("accept did not start sequence");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && stat.out_free |=> state_r == S_IDLE)
    else $error("update did not return to idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !stat.out_free |=> state_r == S_DONE)
    else $error("update overwrote waiting result");

endmodule

@@ src/differential_drive_odometry.sv @@
// top level: differential drive odometry with dead-reckoned pose
`timescale 1ns / 1ps
// Usage
// - input beat: in_tdata carries left and right wheel tick changes (signed 16 bit);
//   a beat is taken when in_tvalid and in_tready are both high
// - each beat advances the pose: mean travel and heading change are formed from
//   the ticks and the programmed registers, rotated by the old heading and added
// - output beat: out_tdata carries x, y (Q16.16 m) and heading (binary angle)
// - cfg port: cfg_we with cfg_index 0 writes meters per tick (Q0.32),
//   index 1 writes inverse track (Q8.24); write only while idle
// - the result is valid once the serial cordic iterations and the multiply
//   sequence through the one shared 33x33 multiplier have run
// - one item at a time: a new beat waits until the sequencer is idle again
// - in_tready is high only while the sequencer is idle; it may be high while a
//   previous result still waits on out_tready
// - a stalled receiver holds the result; the next update waits in its last
//   step until the output register is free, nothing is dropped
// - reset (synchronous, active low) zeroes the pose and both registers
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // left_ticks [15:0], right_ticks [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // pos_x [31:0], pos_y [63:32], heading [95:64]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ddo_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the step counter and the one-hot state
  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd));

  // datapath: multiplier, cordic pair, pose accumulators, output register
  ddo_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the odometry block: streamed tick beats checked against a pose predictor
`timescale 1ns / 1ps
module testbench;
  import ddo_pkg::*;

  localparam int STEPS = 24;
  localparam int SETTLE = 80;      // cycles after the last pose, above block latency
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // left_ticks [15:0], right_ticks [31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // pos_x [31:0], pos_y [63:32], heading [95:64]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hd;
  } pose_t;

  differential_drive_odometry #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #1 clk = ~clk;

  // predictor copy of registers and pose
  logic [31:0] mpt_q, itrack_q, x_q, y_q, hd_q;
  logic [31:0] tick_queue[$];     // pending beats for the driver
  pose_t       pose_queue[$];     // poses still expected
  int          errors = 0;
  int          poses_seen = 0;
  int          idle_cycles = 0;
  bit          hold_sender = 1'b0;
  bit          stim_done = 1'b0;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  // sin/cos of a binary angle, Q2.30
  task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
    logic    flip;
    longint  cx, sy, z, xs, ys;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h80000000;
    cx = 652032875;
    sy = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = floor_shr(cx, i);
      ys = floor_shr(sy, i);
      if (z >= 0) begin
        cx = cx - ys; sy = sy + xs; z = z - longint'(atan_bam(i[4:0]));
      end else begin
        cx = cx + ys; sy = sy - xs; z = z + longint'(atan_bam(i[4:0]));
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
  endtask

  task automatic advance_pose(input logic [31:0] beat);
    longint l, r, mpt, d, df, r40, hi, lx, ly, dx, dy, cd, sd, ch, sh;
    logic [63:0] lo, acc;
    logic [31:0] dh;
    l = longint'($signed(beat[15:0]));
    r = longint'($signed(beat[31:16]));
    mpt = longint'(mpt_q);
    d = floor_shr((l + r) * mpt, 17);
    df = floor_shr((r - l) * mpt, 16);
    if (df > 64'sd2147483647) df = 64'sd2147483647;
    if (df < -64'sd2147483648) df = -64'sd2147483648;
    r40 = df * longint'(itrack_q);
    hi = floor_shr(r40, 24);
    lo = r40 & 64'hFFFFFF;
    acc = 64'(hi) * 64'd683565276 + ((lo * 64'd683565276) >> 24);
    dh = acc[47:16];
    sincos(dh, cd, sd);
    sincos(hd_q, ch, sh);
    lx = floor_shr(d * cd, 30);
    ly = floor_shr(-(d * sd), 30);
    dx = floor_shr(ch * lx - sh * ly, 30);
    dy = floor_shr(sh * lx + ch * ly, 30);
    x_q = x_q + dx[31:0];
    y_q = y_q + dy[31:0];
    hd_q = hd_q + dh;
    pose_queue.push_back('{x: x_q, y: y_q, hd: hd_q});
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // driver: a beat is taken at a rising edge with valid and ready high
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_pose(tick_queue.pop_front());
        send_gap = gap_len();
      end
    end
  end
  always @(negedge clk) begin
    if (!rst_n || hold_sender) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !(in_tready === 1'b0) && tick_queue.size() > 0) begin
      // still offering the same beat until taken
      in_tvalid <= 1'b1;
      in_tdata <= tick_queue[0];
    end else if (send_gap > 0) begin
      send_gap--;
      in_tvalid <= 1'b0;
    end else if (tick_queue.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= tick_queue[0];
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver stall pattern
  int recv_gap = 0;
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = gap_len();
    end
  end

  // monitor: compare each pose beat with the oldest expected one
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = '{x: out_tdata[31:0], y: out_tdata[63:32], hd: out_tdata[95:64]};
        poses_seen++;
        if (pose_queue.size() == 0) begin
          $display("%0t: unexpected pose beat x=%h y=%h hd=%h", $time, got.x, got.y, got.hd);
          errors++;
        end else begin
          want = pose_queue.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: pos_x expected %h actual %h", $time, want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: pos_y expected %h actual %h", $time, want.y, got.y);
            errors++;
          end
          if (got.hd !== want.hd) begin
            $display("%0t: heading expected %h actual %h", $time, want.hd, got.hd);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pack_ticks(logic [15:0] l, logic [15:0] r);
    return {r, l};
  endfunction

  function automatic logic [15:0] rand_ticks();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 40) - 20);
      1: return 16'($urandom_range(0, 2000) - 1000);
      2: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  // wait until every pose is back, then let the block settle
  task automatic drain();
    while (tick_queue.size() > 0 || in_tvalid || pose_queue.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MPT) mpt_q = val;
    else itrack_q = val;
  endtask

  initial begin
    logic [31:0] mpt_set[5];
    logic [31:0] it_set[5];
    mpt_q = '0; itrack_q = '0; x_q = '0; y_q = '0; hd_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero registers: motion is zero
    tick_queue.push_back(pack_ticks(16'd100, 16'd300));
    tick_queue.push_back(pack_ticks(16'h8000, 16'h7FFF));
    drain();

    // directed: extremes, straight lines, spins
    write_reg(REG_MPT, 32'h0010_0000);
    write_reg(REG_ITRACK, 32'h0200_0000);
    tick_queue.push_back(pack_ticks(16'd1000, 16'd1000));
    tick_queue.push_back(pack_ticks(-16'sd1000, 16'd1000));
    tick_queue.push_back(pack_ticks(16'd1000, -16'sd1000));
    tick_queue.push_back(pack_ticks(16'h7FFF, 16'h7FFF));
    tick_queue.push_back(pack_ticks(16'h8000, 16'h8000));
    tick_queue.push_back(pack_ticks(16'h8000, 16'h7FFF));
    tick_queue.push_back(pack_ticks(16'h7FFF, 16'h8000));
    tick_queue.push_back(pack_ticks(16'hFFFF, 16'h0000));
    tick_queue.push_back(pack_ticks(16'h0000, 16'hFFFF));
    tick_queue.push_back(pack_ticks(16'h5555, 16'hAAAA));
    tick_queue.push_back(pack_ticks(16'hAAAA, 16'h5555));
    drain();
    // max registers force df saturation and pose wrap
    write_reg(REG_MPT, 32'hFFFF_FFFF);
    write_reg(REG_ITRACK, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++)
      tick_queue.push_back(pack_ticks(16'h7FFF - 16'(i), 16'h7FFF));
    tick_queue.push_back(pack_ticks(16'h8000, 16'h7FFF));
    tick_queue.push_back(pack_ticks(16'h7FFF, 16'h8000));
    drain();

    // random phases through several register settings
    mpt_set = '{32'h0000_0000, 32'h0001_0000, 32'h0040_0000, 32'hFFFF_FFFF, 32'h0};
    it_set  = '{32'h0100_0000, 32'h0, 32'h0400_0000, 32'hFFFF_FFFF, 32'h0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        mpt_set[ph] = $urandom;
        it_set[ph] = $urandom;
      end
      write_reg(REG_MPT, mpt_set[ph]);
      write_reg(REG_ITRACK, it_set[ph]);
      for (int k = 0; k < 215; k++) begin
        tick_queue.push_back(pack_ticks(rand_ticks(), rand_ticks()));
        if (k == 100) begin
          // sender holds off until all poses have come back
          while (tick_queue.size() > 0 || in_tvalid) @(posedge clk);
          hold_sender = 1'b1;
          while (pose_queue.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    $display("covered %0d pose beats over zero, extreme and random register settings",
             poses_seen);
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
